// ===== hdl/mob_pkg.sv =====
package mob_pkg;

    // channel and mask formats
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int FIELD_BITS       = 16;
    localparam int MASK_BITS        = 8;
    localparam int MASK_FULL        = 255;
    localparam int MASK_ROUND       = 127;
    localparam int NUM_COL          = 3;

    // one pixel pair in, mask with it
    typedef struct packed {
        logic [FIELD_BITS-1:0] base_red;
        logic [FIELD_BITS-1:0] base_green;
        logic [FIELD_BITS-1:0] base_blue;
        logic [FIELD_BITS-1:0] base_alpha;
        logic [FIELD_BITS-1:0] over_red;
        logic [FIELD_BITS-1:0] over_green;
        logic [FIELD_BITS-1:0] over_blue;
        logic [FIELD_BITS-1:0] over_alpha;
        logic [MASK_BITS-1:0]  mask_level;
    } t_pix_in;

    // one blended pixel out
    typedef struct packed {
        logic [FIELD_BITS-1:0] out_red;
        logic [FIELD_BITS-1:0] out_green;
        logic [FIELD_BITS-1:0] out_blue;
        logic [FIELD_BITS-1:0] out_alpha;
    } t_pix_out;

endpackage

// ===== hdl/mob_mix.sv =====
module mob_mix #(
    parameter int CHANNEL_BITS = mob_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    input  mob_pkg::t_pix_in                                  i_pixel,
    output logic                                              o_valid,
    output logic [mob_pkg::NUM_COL-1:0][CHANNEL_BITS:0]       o_col,
    output logic [CHANNEL_BITS-1:0]                           o_div,
    output logic [CHANNEL_BITS-1:0]                           o_alpha
);

    localparam int W   = CHANNEL_BITS;
    localparam int W2  = 2 * CHANNEL_BITS;
    localparam int FW  = (W > mob_pkg::FIELD_BITS) ? W : mob_pkg::FIELD_BITS;
    localparam int NC  = mob_pkg::NUM_COL;
    localparam int N   = W + mob_pkg::MASK_BITS;
    localparam int RW  = N + 1;
    localparam int PW  = N + RW;
    localparam int SH  = N + mob_pkg::MASK_BITS;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SH) + 64'(mob_pkg::MASK_FULL - 1)) / 64'(mob_pkg::MASK_FULL);
    localparam logic [RW-1:0] RECIP = RECIP_WIDE[RW-1:0];
    localparam logic [W-1:0]  FULL  = {W{1'b1}};
    localparam logic [W-1:0]  HALF  = FULL >> 1;
    localparam logic [W:0]    FULL2 = {FULL, 1'b0};

    // clamp a 16-bit field into the channel range
    function automatic logic [W-1:0] sat_ch(input logic [mob_pkg::FIELD_BITS-1:0] v);
        logic [FW-1:0] ext;
        ext = FW'(v);
        return (ext > FW'(FULL)) ? FULL : ext[W-1:0];
    endfunction

    // floor(y / FULL) by folding the high half, then at most two corrections
    function automatic logic [W-1:0] div_full(input logic [W2-1:0] y);
        logic [W-1:0] q0;
        logic [W:0]   rem;
        logic [W:0]   q;
        q0  = y[W2-1:W];
        rem = {1'b0, y[W-1:0]} + {1'b0, q0};
        q   = {1'b0, q0};
        if (rem >= {1'b0, FULL}) begin
            q = q + (W+1)'(1);
        end
        if (rem >= FULL2) begin
            q = q + (W+1)'(1);
        end
        return q[W-1:0];
    endfunction

    logic [7:0]                r_vld;
    logic [3:0][W-1:0]         r0_base, r1_base, r2_base, r3_base, r4_base, r5_base, r6_base;
    logic [3:0][W-1:0]         r0_over;
    logic [NC-1:0][W-1:0]      r1_over, r2_over, r3_over;
    logic [mob_pkg::MASK_BITS-1:0] r0_mask;
    logic                      r0_mz, r1_mz, r2_mz, r3_mz, r4_mz, r5_mz, r6_mz;
    logic [N-1:0]              r1_p;
    logic [PW-1:0]             r2_prod;
    logic [W-1:0]              r3_oa, r3_noa, r4_oa, r5_oa;
    logic [W2-1:0]             r4_ybw;
    logic [NC-1:0][W2-1:0]     r4_yo, r6_yb;
    logic [W-1:0]              r5_bw;
    logic [NC-1:0][W-1:0]      r5_to, r6_to;
    logic [W-1:0]              r6_a;
    logic [NC-1:0][W:0]        r7_c;
    logic [W-1:0]              r7_div, r7_alpha;
    logic [W:0]                n_asum;

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    // combined alpha before clamping
    always_comb begin
        n_asum = {1'b0, r5_oa} + {1'b0, r5_bw};
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        // stage 0: clamp inputs, flag the empty mask
        r0_base[0] <= sat_ch(i_pixel.base_red);
        r0_base[1] <= sat_ch(i_pixel.base_green);
        r0_base[2] <= sat_ch(i_pixel.base_blue);
        r0_base[3] <= sat_ch(i_pixel.base_alpha);
        r0_over[0] <= sat_ch(i_pixel.over_red);
        r0_over[1] <= sat_ch(i_pixel.over_green);
        r0_over[2] <= sat_ch(i_pixel.over_blue);
        r0_over[3] <= sat_ch(i_pixel.over_alpha);
        r0_mask    <= i_pixel.mask_level;
        r0_mz      <= (i_pixel.mask_level == '0);

        // stage 1: overlay alpha times mask, plus rounding
        r1_p    <= N'(r0_over[3]) * N'(r0_mask) + N'(mob_pkg::MASK_ROUND);
        r1_base <= r0_base;
        r1_over <= r0_over[NC-1:0];
        r1_mz   <= r0_mz;

        // stage 2: divide by the mask full scale through a reciprocal
        r2_prod <= PW'(r1_p) * PW'(RECIP);
        r2_base <= r1_base;
        r2_over <= r1_over;
        r2_mz   <= r1_mz;

        // stage 3: masked overlay alpha and its complement
        r3_oa   <= r2_prod[SH +: W];
        r3_noa  <= FULL - r2_prod[SH +: W];
        r3_base <= r2_base;
        r3_over <= r2_over;
        r3_mz   <= r2_mz;

        // stage 4: base weight and overlay colour products
        r4_ybw <= W2'(r3_base[3]) * W2'(r3_noa) + W2'(HALF);
        for (int k = 0; k < NC; k++) begin
            r4_yo[k] <= W2'(r3_over[k]) * W2'(r3_oa) + W2'(HALF);
        end
        r4_oa   <= r3_oa;
        r4_base <= r3_base;
        r4_mz   <= r3_mz;

        // stage 5: scale products back to channel range
        r5_bw <= div_full(r4_ybw);
        for (int k = 0; k < NC; k++) begin
            r5_to[k] <= div_full(r4_yo[k]);
        end
        r5_oa   <= r4_oa;
        r5_base <= r4_base;
        r5_mz   <= r4_mz;

        // stage 6: combined alpha and base colour products
        r6_a <= (n_asum > {1'b0, FULL}) ? FULL : n_asum[W-1:0];
        for (int k = 0; k < NC; k++) begin
            r6_yb[k] <= W2'(r5_base[k]) * W2'(r5_bw) + W2'(HALF);
        end
        r6_to   <= r5_to;
        r6_base <= r5_base;
        r6_mz   <= r5_mz;

        // stage 7: colour sums; empty mask or zero alpha divides by full scale
        for (int k = 0; k < NC; k++) begin
            r7_c[k] <= r6_mz ? {1'b0, r6_base[k]}
                             : {1'b0, r6_to[k]} + {1'b0, div_full(r6_yb[k])};
        end
        r7_div   <= (r6_mz || (r6_a == '0)) ? FULL : r6_a;
        r7_alpha <= r6_mz ? r6_base[3] : r6_a;
    end

    assign o_valid = r_vld[7];
    assign o_col   = r7_c;
    assign o_div   = r7_div;
    assign o_alpha = r7_alpha;

endmodule

// ===== hdl/mob_div.sv =====
module mob_div #(
    parameter int CHANNEL_BITS = mob_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    input  logic [mob_pkg::NUM_COL-1:0][CHANNEL_BITS:0]   i_col,
    input  logic [CHANNEL_BITS-1:0]                       i_div,
    input  logic [CHANNEL_BITS-1:0]                       i_alpha,
    output logic                                          o_valid,
    output logic [mob_pkg::NUM_COL-1:0][CHANNEL_BITS-1:0] o_quo,
    output logic [CHANNEL_BITS-1:0]                       o_alpha
);

    localparam int W  = CHANNEL_BITS;
    localparam int DW = 2 * CHANNEL_BITS + 1;
    localparam int NC = mob_pkg::NUM_COL;

    logic [W:0]                r_vld;
    logic [NC-1:0][DW-1:0]     r_rem [0:W-1];
    logic [NC-1:0][W-1:0]      r_quo [0:W];
    logic [W-1:0]              r_div [0:W];
    logic [W-1:0]              r_alp [0:W];

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[W-1:0], i_valid};
        end
    end

    // entry stage: dividend is colour times full scale
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NC; k++) begin
            r_rem[0][k] <= {i_col[k], W'(0)} - DW'(i_col[k]);
        end
        r_quo[0] <= '0;
        r_div[0] <= i_div;
        r_alp[0] <= i_alpha;
    end

    // restoring division, one quotient bit per stage, most significant first
    for (genvar s = 1; s <= W; s++) begin : g_stage
        localparam int B = W - s;
        logic [DW-1:0]         shifted;
        logic [NC-1:0][DW-1:0] n_rem;
        logic [NC-1:0][W-1:0]  n_quo;

        always_comb begin
            shifted = DW'(r_div[s-1]) << B;
            for (int k = 0; k < NC; k++) begin
                n_rem[k] = r_rem[s-1][k];
                n_quo[k] = r_quo[s-1][k];
                if (r_rem[s-1][k] >= shifted) begin
                    n_rem[k]    = r_rem[s-1][k] - shifted;
                    n_quo[k][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_quo[s] <= n_quo;
            r_div[s] <= r_div[s-1];
            r_alp[s] <= r_alp[s-1];
        end

        // last stage needs no remainder
        if (s < W) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
            end
        end
    end

    assign o_valid = r_vld[W];
    assign o_quo   = r_quo[W];
    assign o_alpha = r_alp[W];

endmodule

// ===== hdl/masked_over_alpha_blend_top.sv =====
// channel     dir  handshake                 payload
// pixel in    in   start high, busy low      i_pixel  (mob_pkg::t_pix_in)
// pixel out   out  o_valid strobe, 1 cycle   o_pixel  (mob_pkg::t_pix_out)
//
// one pixel per clock; results pass through the mix stages, the divider stages and the output register
// the restoring divider resolves one quotient bit per stage
// busy never rises, so a transfer is taken every cycle start is high
// synchronous reset clears the valid bits only; payload registers are not reset
// the receiver cannot stall: each result is shown for exactly one cycle
module masked_over_alpha_blend_top #(
    parameter int CHANNEL_BITS = mob_pkg::CHANNEL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mob_pkg::t_pix_in  i_pixel,
    output logic              o_valid,
    output mob_pkg::t_pix_out o_pixel
);

    localparam int W  = CHANNEL_BITS;
    localparam int FW = (W > mob_pkg::FIELD_BITS) ? W : mob_pkg::FIELD_BITS;
    localparam int NC = mob_pkg::NUM_COL;

    // channel value to output field, low bits kept
    function automatic logic [mob_pkg::FIELD_BITS-1:0] to_field(input logic [W-1:0] v);
        logic [FW-1:0] ext;
        ext = FW'(v);
        return ext[mob_pkg::FIELD_BITS-1:0];
    endfunction

    logic                      mix_valid;
    logic [NC-1:0][W:0]        mix_col;
    logic [W-1:0]              mix_div;
    logic [W-1:0]              mix_alpha;
    logic                      div_valid;
    logic [NC-1:0][W-1:0]      div_quo;
    logic [W-1:0]              div_alpha;
    logic                      r_valid;
    mob_pkg::t_pix_out         r_pixel;

    // pipeline never holds off a transfer
    assign busy = 1'b0;

    // alpha, weights and colour sums
    mob_mix #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_pixel (i_pixel),
        .o_valid (mix_valid),
        .o_col   (mix_col),
        .o_div   (mix_div),
        .o_alpha (mix_alpha)
    );

    // un-premultiply by the combined alpha
    mob_div #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .i_col   (mix_col),
        .i_div   (mix_div),
        .i_alpha (mix_alpha),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_alpha (div_alpha)
    );

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= div_valid;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        r_pixel.out_red   <= to_field(div_quo[0]);
        r_pixel.out_green <= to_field(div_quo[1]);
        r_pixel.out_blue  <= to_field(div_quo[2]);
        r_pixel.out_alpha <= to_field(div_alpha);
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

// ===== test/mob_blend_checker.sv =====
`timescale 1ns / 100ps

module mob_blend_checker #(
    parameter int CHANNEL_BITS = mob_pkg::CHANNEL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  mob_pkg::t_pix_in  i_pixel_in,
    input  logic              i_valid,
    input  mob_pkg::t_pix_out i_pixel_out,
    output int                o_fail_count,
    output int                o_pending
);

    localparam longint unsigned FULL_SCALE = (64'd1 << CHANNEL_BITS) - 64'd1;
    localparam longint unsigned FIELD_ONES = 64'hFFFF;

    // blended pixels still owed by the block, oldest first
    mob_pkg::t_pix_out expected_pixels[$];

    // clip a field to the channel's full scale
    function automatic longint unsigned clip_channel(input longint unsigned v);
        longint unsigned w;
        w = v & FIELD_ONES;
        return (w > FULL_SCALE) ? FULL_SCALE : w;
    endfunction

    function automatic longint unsigned round_div(input longint unsigned x,
                                                  input longint unsigned d);
        return (x + (d >> 1)) / d;
    endfunction

    // source-over blend under the mask, straight alpha in and out
    function automatic mob_pkg::t_pix_out blend_pixel(input mob_pkg::t_pix_in p);
        longint unsigned   base_ch[4];
        longint unsigned   over_ch[4];
        longint unsigned   res_ch[4];
        longint unsigned   mask_v;
        longint unsigned   eff_alpha;
        longint unsigned   base_wt;
        longint unsigned   alpha_sum;
        longint unsigned   colour;
        mob_pkg::t_pix_out r;
        base_ch[0] = clip_channel(p.base_red);
        base_ch[1] = clip_channel(p.base_green);
        base_ch[2] = clip_channel(p.base_blue);
        base_ch[3] = clip_channel(p.base_alpha);
        over_ch[0] = clip_channel(p.over_red);
        over_ch[1] = clip_channel(p.over_green);
        over_ch[2] = clip_channel(p.over_blue);
        over_ch[3] = clip_channel(p.over_alpha);
        mask_v     = p.mask_level;

        if (mask_v == 0) begin
            // unselected pixel passes the base through
            for (int i = 0; i < 4; i++) res_ch[i] = base_ch[i];
        end else begin
            eff_alpha = round_div(over_ch[3] * mask_v, mob_pkg::MASK_FULL);
            base_wt   = round_div(base_ch[3] * (FULL_SCALE - eff_alpha), FULL_SCALE);
            alpha_sum = eff_alpha + base_wt;
            if (alpha_sum > FULL_SCALE) alpha_sum = FULL_SCALE;
            for (int i = 0; i < mob_pkg::NUM_COL; i++) begin
                colour = round_div(over_ch[i] * eff_alpha, FULL_SCALE)
                       + round_div(base_ch[i] * base_wt, FULL_SCALE);
                // un-premultiply, unless the pixel ended up fully clear
                if (alpha_sum != 0) colour = (colour * FULL_SCALE) / alpha_sum;
                if (colour > FULL_SCALE) colour = FULL_SCALE;
                res_ch[i] = colour;
            end
            res_ch[3] = alpha_sum;
        end

        r.out_red   = res_ch[0][mob_pkg::FIELD_BITS-1:0];
        r.out_green = res_ch[1][mob_pkg::FIELD_BITS-1:0];
        r.out_blue  = res_ch[2][mob_pkg::FIELD_BITS-1:0];
        r.out_alpha = res_ch[3][mob_pkg::FIELD_BITS-1:0];
        return r;
    endfunction

    task automatic check_field(input string name,
                               input logic [mob_pkg::FIELD_BITS-1:0] exp_v,
                               input logic [mob_pkg::FIELD_BITS-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // results first, then the new transfer, both sampled at the edge
    always @(posedge i_clk) begin
        mob_pkg::t_pix_out exp_pix;
        if (i_rst_n) begin
            if (i_valid === 1'b1) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: out_red %0d out_green %0d out_blue %0d %s %0d",
                           i_pixel_out.out_red, i_pixel_out.out_green,
                           i_pixel_out.out_blue, "out_alpha", i_pixel_out.out_alpha);
                    o_fail_count++;
                end else begin
                    exp_pix = expected_pixels.pop_front();
                    check_field("out_red",   exp_pix.out_red,   i_pixel_out.out_red);
                    check_field("out_green", exp_pix.out_green, i_pixel_out.out_green);
                    check_field("out_blue",  exp_pix.out_blue,  i_pixel_out.out_blue);
                    check_field("out_alpha", exp_pix.out_alpha, i_pixel_out.out_alpha);
                end
            end
            if (i_start && !i_busy) begin
                expected_pixels.insert(expected_pixels.size(), blend_pixel(i_pixel_in));
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ===== test/masked_over_alpha_blend_top_tb.sv =====
`timescale 1ns / 100ps

module masked_over_alpha_blend_top_tb;

    localparam int CHANNEL_BITS  = mob_pkg::CHANNEL_BITS_DEF;
    localparam int LATENCY       = CHANNEL_BITS + 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 270;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    mob_pkg::t_pix_in  i_pixel = '0;
    logic              o_valid;
    mob_pkg::t_pix_out o_pixel;
    int                fail_count;
    int                pending;
    int                quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    masked_over_alpha_blend_top #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .o_pixel (o_pixel)
    );

    mob_blend_checker #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) blend_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_pixel_in   (i_pixel),
        .i_valid      (o_valid),
        .i_pixel_out  (o_pixel),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: too long with no transfer either way ends the run
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic mob_pkg::t_pix_in make_pixel(
        input logic [15:0] br, input logic [15:0] bg, input logic [15:0] bb,
        input logic [15:0] ba, input logic [15:0] vr, input logic [15:0] vg,
        input logic [15:0] vb, input logic [15:0] va, input logic [7:0] m);
        mob_pkg::t_pix_in p;
        p.base_red   = br;
        p.base_green = bg;
        p.base_blue  = bb;
        p.base_alpha = ba;
        p.over_red   = vr;
        p.over_green = vg;
        p.over_blue  = vb;
        p.over_alpha = va;
        p.mask_level = m;
        return p;
    endfunction

    // channel values lean towards the ends of the range
    function automatic logic [15:0] rand_channel();
        int pick;
        pick = $urandom_range(15);
        if (pick < 2) return 16'h0000;
        if (pick < 4) return 16'hFFFF;
        if (pick < 5) return 16'($urandom_range(3));
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand_mask();
        int pick;
        pick = $urandom_range(15);
        if (pick < 2) return 8'd0;
        if (pick < 5) return 8'd255;
        if (pick < 6) return 8'd1;
        return 8'($urandom);
    endfunction

    function automatic mob_pkg::t_pix_in rand_pixel();
        return make_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                          rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                          rand_mask());
    endfunction

    // one transfer, preceded by random gaps
    task automatic send_pixel(input mob_pkg::t_pix_in p, input int gap_pct);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // hold off until every blended pixel has come back
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        // reset
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, mask ends, clear and opaque cases
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 255), 0);
        send_pixel(make_pixel('1, '1, '1, '1, '1, '1, '1, '1, 255), 0);
        send_pixel(make_pixel('1, '1, '1, '1, '1, '1, '1, '1, 0), 0);
        send_pixel(make_pixel(16'h1234, 16'hABCD, 16'h8001, 16'h7FFF,
                              '1, '1, '1, '1, 0), 0);
        send_pixel(make_pixel('1, '1, '1, 0, '1, '1, '1, 0, 255), 0);
        send_pixel(make_pixel(16'h4000, 16'hC000, 16'hFFFF, '1,
                              16'h0001, 16'h8000, 0, 0, 128), 0);
        send_pixel(make_pixel(16'h5555, 16'hAAAA, 16'h0F0F, 16'h9999,
                              16'h1111, 16'hEEEE, 16'h7777, '1, 255), 0);
        send_pixel(make_pixel(0, 0, 0, 0, '1, '1, '1, '1, 1), 0);
        send_pixel(make_pixel('1, 0, '1, '1, 0, '1, 0, 16'h0001, 1), 0);
        send_pixel(make_pixel('1, '1, '1, 16'h0001, 0, 0, 0, 0, 255), 0);
        send_pixel(make_pixel('1, '1, '1, 16'h0001, 0, 0, 0, 16'h0001, 255), 0);
        send_pixel(make_pixel(0, 0, 0, 16'h8000, '1, '1, '1, 16'h8000, 255), 0);
        send_pixel(make_pixel('1, '1, '1, 16'h8000, 0, 0, 0, 16'h8000, 127), 0);
        send_pixel(make_pixel(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                              16'h5555, 16'h5555, 16'h5555, 16'h5555, 8'hAA), 0);
        send_pixel(make_pixel(16'h5555, 16'h5555, 16'h5555, 16'h5555,
                              16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 8'h55), 0);
        send_pixel(make_pixel(16'h0001, 16'h0001, 16'h0001, '1,
                              16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 254), 0);
        send_pixel(make_pixel('1, '1, '1, '1, 0, 0, 0, 16'h00FF, 2), 0);
        wait_drained();

        // random: sender gaps light, then heavy, then none
        repeat (PHASE_ITEMS) send_pixel(rand_pixel(), 31);
        wait_drained();
        repeat (PHASE_ITEMS) send_pixel(rand_pixel(), 73);
        wait_drained();
        repeat (PHASE_ITEMS) send_pixel(rand_pixel(), 0);
        wait_drained();

        // allow for any stray result after the last expected one
        repeat (LATENCY + 4) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== masked_over_alpha_blend_top.f =====
hdl/mob_pkg.sv
hdl/mob_mix.sv
hdl/mob_div.sv
hdl/masked_over_alpha_blend_top.sv
test/mob_blend_checker.sv
test/masked_over_alpha_blend_top_tb.sv
